// ----- rtl/lcsl_pkg.sv -----
// Shared types and constants of the longest common substring length core.
`default_nettype none

package lcsl_pkg;

  localparam int unsigned MAX_STORED_LEN_DEF = 64;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned LEN_W = 7;
  localparam logic [LEN_W-1:0] LEN_MAX = 7'd127;
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_STREAM = 1'b1;

  typedef enum logic {
    CMD_STORE,
    CMD_STREAM
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic             restart;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/lcsl_front.sv -----
// Front end: accepts requests and turns them into store or stream commands.
`default_nettype none

module lcsl_front import lcsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic             full_i,
  input  logic             operation_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             last_i,
  output logic             cmd_push_o,
  output cmd_t             cmd_o
);

  logic load_done_q, load_done_d;
  logic accept;

  assign accept = push_i && !full_i;
  assign cmd_push_o = accept;

  always_comb begin
    load_done_d = load_done_q;
    cmd_o.symbol = symbol_i;
    cmd_o.last = last_i;
    cmd_o.restart = 1'b0;
    unique case (operation_i)
      OP_STORE: begin
        cmd_o.kind = CMD_STORE;
        cmd_o.restart = load_done_q;
        if (accept) begin
          load_done_d = last_i;
        end
      end
      OP_STREAM: begin
        cmd_o.kind = CMD_STREAM;
      end
      default: begin
        cmd_o.kind = CMD_STREAM;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_done_q <= 1'b0;
    end else begin
      load_done_q <= load_done_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lcsl_fifo.sv -----
// Short command queue between the front end and the compare engine.
`default_nettype none

module lcsl_fifo import lcsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  localparam int unsigned PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned NW = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [PW-1:0] PtrLast = PW'(CMD_FIFO_DEPTH - 1);
  localparam logic [NW-1:0] NumFull = NW'(CMD_FIFO_DEPTH);

  cmd_t            slots_q [CMD_FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   num_q, num_d;
  logic            do_push, do_pop;

  assign full_o = (num_q == NumFull);
  assign empty_o = (num_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    num_d = num_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      num_d = num_q + NW'(1);
    end else if (do_pop && !do_push) begin
      num_d = num_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      num_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      num_q <= num_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lcsl_back.sv -----
// Compare engine: stored string buffer, run-length row walk and result register.
`default_nettype none

module lcsl_back import lcsl_pkg::*; #(
  parameter int unsigned MAX_STORED_LEN = MAX_STORED_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic             cmd_empty_i,
  output logic             cmd_pop_o,
  output logic             out_empty_o,
  input  logic             out_pop_i,
  output logic [LEN_W-1:0] longest_length_o,
  output logic             truncated_o
);

  localparam int unsigned AW = (MAX_STORED_LEN > 1) ? $clog2(MAX_STORED_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_STORED_LEN + 1);
  localparam logic [CW-1:0] CountMax = CW'(MAX_STORED_LEN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    row_hi_q, row_hi_d;
  logic [LEN_W-1:0] best_q, best_d;
  logic             ovf_q, ovf_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [LEN_W-1:0] prev_q, prev_d;
  logic [SYM_W-1:0] sym_q, sym_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [LEN_W-1:0] out_len_q, out_len_d;
  logic             out_trunc_q, out_trunc_d;

  logic [SYM_W-1:0] sym_mem [MAX_STORED_LEN];
  logic [LEN_W-1:0] row_mem [MAX_STORED_LEN];
  logic [SYM_W-1:0] sym_rd_q;
  logic [LEN_W-1:0] row_rd_q;

  logic             sym_we;
  logic [AW-1:0]    sym_waddr;
  logic             row_we;
  logic [AW-1:0]    rd_addr;
  logic [CW-1:0]    count_eff;
  logic [CW-1:0]    idx_ext;
  logic [LEN_W-1:0] row_old;
  logic [LEN_W-1:0] run_val;

  assign idx_ext = CW'(idx_q);
  assign row_old = (idx_ext < row_hi_q) ? row_rd_q : '0;
  assign run_val = (sym_rd_q != sym_q) ? '0 :
                   (prev_q == LEN_MAX) ? LEN_MAX : prev_q + LEN_W'(1);

  assign out_empty_o = !out_valid_q;
  assign longest_length_o = out_len_q;
  assign truncated_o = out_trunc_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    row_hi_d = row_hi_q;
    best_d = best_q;
    ovf_d = ovf_q;
    idx_d = idx_q;
    prev_d = prev_q;
    sym_d = sym_q;
    last_d = last_q;
    out_valid_d = out_valid_q && !out_pop_i;
    out_len_d = out_len_q;
    out_trunc_d = out_trunc_q;
    cmd_pop_o = 1'b0;
    sym_we = 1'b0;
    sym_waddr = count_q[AW-1:0];
    row_we = 1'b0;
    rd_addr = idx_q + AW'(1);
    count_eff = count_q;
    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == CMD_STORE) begin
            if (cmd_i.restart) begin
              count_eff = '0;
              ovf_d = 1'b0;
              row_hi_d = '0;
              best_d = '0;
            end
            if (count_eff < CountMax) begin
              sym_we = 1'b1;
              sym_waddr = count_eff[AW-1:0];
              count_d = count_eff + CW'(1);
            end else begin
              count_d = count_eff;
              ovf_d = 1'b1;
            end
          end else begin
            sym_d = cmd_i.symbol;
            last_d = cmd_i.last;
            idx_d = '0;
            prev_d = '0;
            rd_addr = '0;
            if (count_q != '0) begin
              state_d = S_WALK;
            end else if (cmd_i.last) begin
              state_d = S_EMIT;
            end
          end
        end
      end
      S_WALK: begin
        row_we = 1'b1;
        prev_d = row_old;
        best_d = (run_val > best_q) ? run_val : best_q;
        idx_d = idx_q + AW'(1);
        if (idx_ext == count_q - CW'(1)) begin
          row_hi_d = count_q;
          state_d = last_q ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_pop_i) begin
          out_valid_d = 1'b1;
          out_len_d = best_q;
          out_trunc_d = ovf_q;
          best_d = '0;
          row_hi_d = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sym_we) begin
      sym_mem[sym_waddr] <= cmd_i.symbol;
    end
    sym_rd_q <= sym_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[idx_q] <= run_val;
    end
    row_rd_q <= row_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      row_hi_q <= '0;
      best_q <= '0;
      ovf_q <= 1'b0;
      idx_q <= '0;
      prev_q <= '0;
      sym_q <= '0;
      last_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_len_q <= '0;
      out_trunc_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      row_hi_q <= row_hi_d;
      best_q <= best_d;
      ovf_q <= ovf_d;
      idx_q <= idx_d;
      prev_q <= prev_d;
      sym_q <= sym_d;
      last_q <= last_d;
      out_valid_q <= out_valid_d;
      out_len_q <= out_len_d;
      out_trunc_q <= out_trunc_d;
    end
  end

`ifndef SYNTHESIS
  a_row_within_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_hi_q <= count_q)
    else $error("Valid row span exceeds the stored string length.");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> idx_ext < count_q)
    else $error("Row walk index ran past the stored string.");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !cmd_empty_i)
    else $error("Command taken from an empty queue.");

  a_emit_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
    else $error("Result not loaded into a free output register.");
`endif

endmodule

`default_nettype wire

// ----- rtl/longest_common_substring_length_core.sv -----
// Top level of the longest common substring length core.
// A stored-string request is taken in the engine's idle state; a streamed request then walks
// the run-length row memory over the N stored entries at one entry per cycle; a final
// streamed request also loads the result register once that register is free.
// Reset is asynchronous and active low; it empties both queues and clears the search.
`default_nettype none

module longest_common_substring_length_core import lcsl_pkg::*; #(
  parameter int unsigned MAX_STORED_LEN = MAX_STORED_LEN_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             operation_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic             last_i,
  output logic             empty,
  input  logic             pop,
  output logic [LEN_W-1:0] longest_length_o,
  output logic             truncated_o
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic front_push;
  logic queue_empty;
  logic queue_pop;

  lcsl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .operation_i(operation_i),
    .symbol_i   (symbol_i),
    .last_i     (last_i),
    .cmd_push_o (front_push),
    .cmd_o      (front_cmd)
  );

  lcsl_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_cmd),
    .full_o (full),
    .pop_i  (queue_pop),
    .data_o (queue_cmd),
    .empty_o(queue_empty)
  );

  lcsl_back #(
    .MAX_STORED_LEN(MAX_STORED_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (queue_cmd),
    .cmd_empty_i     (queue_empty),
    .cmd_pop_o       (queue_pop),
    .out_empty_o     (empty),
    .out_pop_i       (pop),
    .longest_length_o(longest_length_o),
    .truncated_o     (truncated_o)
  );

endmodule

`default_nettype wire

// ----- test/longest_common_substring_length_core_test.sv -----
// Self-checking testbench for the longest common substring length core with a scoreboard.
`default_nettype none

module longest_common_substring_length_core_test import lcsl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = MAX_STORED_LEN_DEF;
  localparam int unsigned TOTAL_ITEMS = 950;
  localparam int unsigned SETTLE_CYCLES = 4 * (DEPTH + 3);
  localparam int unsigned TEXT_MAX = DEPTH + 8;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             trunc;
  } lcs_result_t;

  class lcs_scoreboard;
    logic [SYM_W-1:0] stored_bytes [DEPTH];
    int unsigned      run_lengths [DEPTH];
    int unsigned      stored_len;
    int unsigned      best_len;
    bit               load_done;
    bit               overflow;
    lcs_result_t      pending [$];
    int unsigned      mismatches;
    int unsigned      checked;
    int unsigned      truncated_seen;
    int unsigned      longest_seen;

    function new();
      foreach (run_lengths[j]) run_lengths[j] = 0;
      stored_len = 0;
      best_len = 0;
      load_done = 0;
      overflow = 0;
      mismatches = 0;
      checked = 0;
      truncated_seen = 0;
      longest_seen = 0;
    endfunction

    function void clear_search();
      foreach (run_lengths[j]) run_lengths[j] = 0;
      best_len = 0;
    endfunction

    function void note_request(logic op, logic [SYM_W-1:0] sym, logic fin);
      int unsigned v;
      lcs_result_t res;
      if (op == OP_STORE) begin
        if (load_done) begin
          stored_len = 0;
          overflow = 0;
          load_done = 0;
          clear_search();
        end
        if (stored_len < DEPTH) begin
          stored_bytes[stored_len] = sym;
          stored_len++;
        end else begin
          overflow = 1;
        end
        if (fin) load_done = 1;
      end else begin
        // Walking downward keeps entry k-1 at its value from the previous byte.
        for (int k = int'(stored_len) - 1; k >= 0; k--) begin
          v = 0;
          if (stored_bytes[k] == sym) begin
            v = ((k > 0) ? run_lengths[k-1] : 0) + 1;
            if (v > LEN_MAX) v = LEN_MAX;
          end
          run_lengths[k] = v;
          if (v > best_len) best_len = v;
        end
        if (fin) begin
          res.len = (best_len > LEN_MAX) ? LEN_MAX : LEN_W'(best_len);
          res.trunc = overflow;
          pending.push_back(res);
          clear_search();
        end
      end
    endfunction

    task report_mismatch(input string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(input logic [LEN_W-1:0] len, input logic trunc);
      lcs_result_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result length %0d truncated %0b with no request waiting",
                                  len, trunc));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (len !== want.len)
        report_mismatch($sformatf("longest_length %0d, expected %0d", len, want.len));
      if (trunc !== want.trunc)
        report_mismatch($sformatf("truncated %0b, expected %0b", trunc, want.trunc));
      if (trunc === 1'b1) truncated_seen++;
      if (len > longest_seen) longest_seen = len;
    endtask

    task check_drained();
      if (pending.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", pending.size()));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  logic             operation_i;
  logic [SYM_W-1:0] symbol_i;
  logic             last_i;
  logic             empty;
  logic             pop;
  logic [LEN_W-1:0] longest_length_o;
  logic             truncated_o;

  lcs_scoreboard    board;
  int unsigned      n_sent;
  int unsigned      n_streamed;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  logic [SYM_W-1:0] text_buf [TEXT_MAX];
  int unsigned      text_len;
  logic [SYM_W-1:0] alpha_base;

  longest_common_substring_length_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .operation_i     (operation_i),
    .symbol_i        (symbol_i),
    .last_i          (last_i),
    .empty           (empty),
    .pop             (pop),
    .longest_length_o(longest_length_o),
    .truncated_o     (truncated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_request(input logic op, input logic [SYM_W-1:0] sym, input logic fin);
    if (n_sent * 3 < TOTAL_ITEMS) begin
      send_idle_pct = 31;
      recv_idle_pct = 47;
    end else if (n_sent * 3 < 2 * TOTAL_ITEMS) begin
      send_idle_pct = 47;
      recv_idle_pct = 31;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    push <= 1'b1;
    operation_i <= op;
    symbol_i <= sym;
    last_i <= fin;
    do @(posedge clk_i); while (full);
    board.note_request(op, sym, fin);
    n_sent++;
    if (op == OP_STREAM) n_streamed++;
  endtask

  task automatic load_text(input int unsigned len, input bit wide_bytes);
    logic [SYM_W-1:0] sym;
    alpha_base = SYM_W'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      sym = wide_bytes ? SYM_W'($urandom) : alpha_base + SYM_W'($urandom_range(3));
      if (i < TEXT_MAX) text_buf[i] = sym;
      send_request(OP_STORE, sym, i == len - 1);
    end
    text_len = (len < DEPTH) ? len : DEPTH;
  endtask

  task automatic stream_text(input int unsigned len);
    logic [SYM_W-1:0] sym;
    int unsigned      pos;
    int unsigned      r;
    pos = (text_len > 0) ? $urandom_range(text_len - 1) : 0;
    for (int unsigned i = 0; i < len; i++) begin
      r = $urandom_range(99);
      if (text_len == 0 || r < 10) begin
        sym = SYM_W'($urandom);
      end else if (r < 70) begin
        if (pos >= text_len) pos = $urandom_range(text_len - 1);
        sym = text_buf[pos];
        if ($urandom_range(9) == 0) sym = sym ^ (SYM_W'(1) << $urandom_range(SYM_W - 1));
        pos++;
      end else begin
        sym = text_buf[$urandom_range(text_len - 1)];
      end
      send_request(OP_STREAM, sym, i == len - 1);
    end
  endtask

  initial begin
    int unsigned seq;
    int unsigned r;
    int unsigned len;
    rst_ni = 1'b0;
    push = 1'b0;
    operation_i = OP_STORE;
    symbol_i = '0;
    last_i = 1'b0;
    n_sent = 0;
    n_streamed = 0;
    send_idle_pct = 31;
    recv_idle_pct = 47;
    text_len = 0;
    alpha_base = '0;
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With nothing stored every streamed string has length zero.
    send_request(OP_STREAM, 8'h5A, 1'b1);
    send_request(OP_STREAM, 8'h00, 1'b0);
    send_request(OP_STREAM, 8'hFF, 1'b1);
    send_request(OP_STORE, 8'h00, 1'b0);
    send_request(OP_STORE, 8'hFF, 1'b0);
    send_request(OP_STORE, 8'h41, 1'b1);
    send_request(OP_STREAM, 8'h00, 1'b0);
    send_request(OP_STREAM, 8'hFF, 1'b0);
    send_request(OP_STREAM, 8'h41, 1'b1);
    send_request(OP_STREAM, 8'hFF, 1'b1);
    send_request(OP_STREAM, 8'h41, 1'b0);
    send_request(OP_STREAM, 8'h00, 1'b1);
    // A stored byte after a finished load starts a new string; stream before it ends.
    send_request(OP_STORE, 8'h7E, 1'b0);
    send_request(OP_STREAM, 8'h7E, 1'b1);
    send_request(OP_STORE, 8'h80, 1'b1);
    send_request(OP_STREAM, 8'h7E, 1'b0);
    send_request(OP_STREAM, 8'h80, 1'b1);
    send_request(OP_STORE, 8'h33, 1'b1);
    send_request(OP_STREAM, 8'h33, 1'b0);
    send_request(OP_STREAM, 8'h33, 1'b1);

    seq = 0;
    while (n_sent < TOTAL_ITEMS) begin
      if (seq % 20 == 7) begin
        // Full buffer of one byte streamed longer than the buffer gives the full buffer length.
        alpha_base = SYM_W'($urandom);
        for (int unsigned i = 0; i < DEPTH; i++) begin
          text_buf[i] = alpha_base;
          send_request(OP_STORE, alpha_base, i == DEPTH - 1);
        end
        text_len = DEPTH;
        for (int unsigned i = 0; i < DEPTH + 2; i++)
          send_request(OP_STREAM, alpha_base, i == DEPTH + 1);
      end else if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(1, 8))
          send_request(1'($urandom_range(1)), SYM_W'($urandom), 1'($urandom_range(1)));
      end else begin
        r = $urandom_range(99);
        if (r < 8) len = DEPTH;
        else if (r < 16) len = $urandom_range(DEPTH + 1, TEXT_MAX);
        else len = $urandom_range(1, 12);
        load_text(len, $urandom_range(3) == 0);
        repeat ($urandom_range(1, 4)) stream_text($urandom_range(1, 12));
      end
      seq++;
    end
    push <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    board.check_drained();
    $display("Sent %0d requests (%0d streamed bytes) over %0d sequences.",
             n_sent, n_streamed, seq);
    $display("Checked %0d results, %0d truncated, longest length %0d.",
             board.checked, board.truncated_seen, board.longest_seen);
    if (board.mismatches == 0) begin
      $display("longest_common_substring_length_core test passed");
    end else begin
      $display("longest_common_substring_length_core test failed");
    end
    $finish;
  end

  initial begin
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk_i);
      if (pop && !empty) board.check_result(longest_length_o, truncated_o);
    end
  end

  initial begin
    #20_000_000;
    $display("Timeout waiting for the core to finish.");
    $display("longest_common_substring_length_core test failed");
    $finish;
  end

endmodule

`default_nettype wire
